@@ rtl/mbd_pkg.sv @@
// shared types, constants and the rounding average for the mipmap box downsampler
`timescale 1ns / 1ps

package mbd_pkg;

   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int QUEUE_DEPTH       = 4;

   localparam int WIDTH_BITS  = 13;
   localparam int HEIGHT_BITS = 16;
   localparam int CSR_DATA_W  = 16;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 13'd4;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd2;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] channel_0;
      logic [7:0] channel_1;
      logic [7:0] channel_2;
      logic [7:0] channel_3;
   } req_type;

   typedef struct packed {
      logic [7:0] out_channel_0;
      logic [7:0] out_channel_1;
      logic [7:0] out_channel_2;
      logic [7:0] out_channel_3;
      logic       frame_last;
   } rsp_type;

   // what the back end does with a queued pixel
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_HOLD  = 2'd1,
      OP_EMIT  = 2'd2
   } op_type;

   typedef struct packed {
      op_type  op;
      req_type pixel;
      logic    last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic stage_valid;
      logic emit_fire;
   } back_stat_type;

   // per channel (a+b+1)>>1
   function automatic req_type avg_up(input req_type a, input req_type b);
      logic [31:0] va;
      logic [31:0] vb;
      logic [31:0] r;
      logic [8:0]  s;
      va = a;
      vb = b;
      r  = '0;
      for (int k = 0; k < 4; k++) begin
         s = {1'b0, va[8*k +: 8]} + {1'b0, vb[8*k +: 8]} + 9'd1;
         r[8*k +: 8] = s[8:1];
      end
      return req_type'(r);
   endfunction

endpackage

@@ rtl/mbd_front.sv @@
// front end: size registers, raster counters and pixel classification
`timescale 1ns / 1ps

module mbd_front #(
   parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEFAULT,
   parameter int AW        = $clog2(MAX_WIDTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mbd_pkg::req_type              req_data,
   input  mbd_pkg::queue_stat_type       q_stat,
   output logic                          push,
   output mbd_pkg::cmd_type              push_cmd,
   output logic [AW-1:0]                 push_slot
);

   localparam int WW = ($clog2(MAX_WIDTH + 1) > mbd_pkg::WIDTH_BITS) ?
                       $clog2(MAX_WIDTH + 1) : mbd_pkg::WIDTH_BITS;

   logic [mbd_pkg::WIDTH_BITS-1:0]  width_ff,  width_in;
   logic [mbd_pkg::HEIGHT_BITS-1:0] height_ff, height_in;
   logic [mbd_pkg::WIDTH_BITS-1:0]  col_ff,    col_in;
   logic [mbd_pkg::HEIGHT_BITS-1:0] row_ff,    row_in;

   logic                            accept;
   logic [WW-1:0]                   w_eff;
   logic [WW-1:0]                   used_w;
   logic [mbd_pkg::HEIGHT_BITS-1:0] used_h;
   logic                            in_frame;
   logic [mbd_pkg::WIDTH_BITS:0]    col_next;
   logic [mbd_pkg::HEIGHT_BITS:0]   row_next;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;

   // widths above the line store are clipped, odd edges dropped
   assign w_eff  = (WW'(width_ff) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_ff);
   assign used_w = w_eff & ~WW'(1);
   assign used_h = height_ff & ~mbd_pkg::HEIGHT_BITS'(1);

   assign in_frame = (WW'(col_ff) < used_w) && (row_ff < used_h);

   always_comb begin
      push_cmd.pixel = req_data;
      push_cmd.last  = (row_ff == used_h - mbd_pkg::HEIGHT_BITS'(1)) &&
                       (WW'(col_ff) == used_w - WW'(1));
      if (!row_ff[0]) begin
         push_cmd.op = mbd_pkg::OP_WRITE;
      end else if (!col_ff[0]) begin
         push_cmd.op = mbd_pkg::OP_HOLD;
      end else begin
         push_cmd.op = mbd_pkg::OP_EMIT;
      end
   end

   assign push_slot = AW'(col_ff);
   assign push      = accept && in_frame;

   assign col_next = {1'b0, col_ff} + (mbd_pkg::WIDTH_BITS + 1)'(1);
   assign row_next = {1'b0, row_ff} + (mbd_pkg::HEIGHT_BITS + 1)'(1);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mbd_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata[mbd_pkg::WIDTH_BITS-1:0];
            mbd_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata[mbd_pkg::HEIGHT_BITS-1:0];
            default:                   width_in  = width_ff;
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_next >= {1'b0, width_ff}) begin
            col_in = '0;
            if (row_next >= {1'b0, height_ff}) begin
               row_in = '0;
            end else begin
               row_in = row_next[mbd_pkg::HEIGHT_BITS-1:0];
            end
         end else begin
            col_in = col_next[mbd_pkg::WIDTH_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mbd_pkg::WIDTH_RESET;
         height_ff <= mbd_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

@@ rtl/mbd_queue.sv @@
// short command queue between front and back end
`timescale 1ns / 1ps

module mbd_queue #(
   parameter int AW = $clog2(mbd_pkg::MAX_WIDTH_DEFAULT)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  mbd_pkg::cmd_type        push_cmd,
   input  logic [AW-1:0]           push_slot,
   input  logic                    pop,
   output mbd_pkg::cmd_type        head_cmd,
   output logic [AW-1:0]           head_slot,
   output mbd_pkg::queue_stat_type q_stat
);

   localparam int PW = $clog2(mbd_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(mbd_pkg::QUEUE_DEPTH + 1);

   mbd_pkg::cmd_type cmd_ff  [mbd_pkg::QUEUE_DEPTH];
   logic [AW-1:0]    slot_ff [mbd_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff,  count_in;

   assign q_stat.full  = (count_ff == CW'(mbd_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head_cmd     = cmd_ff[rd_ptr_ff];
   assign head_slot    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(mbd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(mbd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff]  <= push_cmd;
         slot_ff[wr_ptr_ff] <= push_slot;
      end
   end

endmodule

@@ rtl/mbd_back.sv @@
// back end: line store, vertical and horizontal averaging, output register
`timescale 1ns / 1ps

module mbd_back #(
   parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEFAULT,
   parameter int AW        = $clog2(MAX_WIDTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mbd_pkg::queue_stat_type q_stat,
   input  mbd_pkg::cmd_type        head_cmd,
   input  logic [AW-1:0]           head_slot,
   output logic                    pop,
   output mbd_pkg::back_stat_type  b_stat,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mbd_pkg::rsp_type        rsp_data
);

   mbd_pkg::req_type line_mem [MAX_WIDTH];

   logic             b_valid_ff;
   mbd_pkg::cmd_type b_cmd_ff;
   mbd_pkg::req_type above_ff;
   mbd_pkg::req_type held_ff;
   logic             out_valid_ff;
   mbd_pkg::rsp_type out_ff;

   logic             out_free;
   logic             b_fire;
   mbd_pkg::req_type vert;
   mbd_pkg::req_type horiz;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign b_fire   = b_valid_ff && ((b_cmd_ff.op != mbd_pkg::OP_EMIT) || out_free);
   assign pop      = !q_stat.empty && (!b_valid_ff || b_fire);

   assign vert  = mbd_pkg::avg_up(above_ff, b_cmd_ff.pixel);
   assign horiz = mbd_pkg::avg_up(held_ff, vert);

   assign b_stat.stage_valid = b_valid_ff;
   assign b_stat.emit_fire   = b_fire && (b_cmd_ff.op == mbd_pkg::OP_EMIT);

   // single port line store, read data registered with the command
   always_ff @(posedge clock) begin
      if (pop) begin
         above_ff <= line_mem[head_slot];
         b_cmd_ff <= head_cmd;
         if (head_cmd.op == mbd_pkg::OP_WRITE) begin
            line_mem[head_slot] <= head_cmd.pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            b_valid_ff <= 1'b1;
         end else if (b_fire) begin
            b_valid_ff <= 1'b0;
         end
         if (b_fire && (b_cmd_ff.op == mbd_pkg::OP_HOLD)) begin
            held_ff <= vert;
         end
         if (b_stat.emit_fire) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_stat.emit_fire) begin
         out_ff.out_channel_0 <= horiz.channel_0;
         out_ff.out_channel_1 <= horiz.channel_1;
         out_ff.out_channel_2 <= horiz.channel_2;
         out_ff.out_channel_3 <= horiz.channel_3;
         out_ff.frame_last    <= b_cmd_ff.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ rtl/mipmap_box_downsample_rgba_core.sv @@
// top level of the 2x2 box mipmap downsampler for rgba8 pixel streams
//
//   channel  dir  handshake          payload
//   req      in   req_valid/stall    source pixel, four bytes, raster order
//   rsp      out  rsp_valid/stall    averaged pixel plus frame_last
//   csr      in   csr_wr_en          csr_index, csr_wdata (width, height)
//
// one source pixel per cycle sustained while rsp_stall is low; the front end
// counts raster position, a four entry queue feeds the back end, which does
// one line store access per pixel; queue, back stage and output are registered.
// synchronous reset clears counters, queue, held average and output valid.
// rsp_stall backs up through the queue; req_stall rises only when it is full.
`timescale 1ns / 1ps

module mipmap_box_downsample_rgba_core #(
   parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mbd_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mbd_pkg::rsp_type               rsp_data
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic                    push;
   logic                    pop;
   mbd_pkg::cmd_type        push_cmd;
   mbd_pkg::cmd_type        head_cmd;
   logic [AW-1:0]           push_slot;
   logic [AW-1:0]           head_slot;
   mbd_pkg::queue_stat_type q_stat;
   mbd_pkg::back_stat_type  b_stat;

   mbd_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_cmd  (push_cmd),
      .push_slot (push_slot)
   );

   mbd_queue #(
      .AW (AW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .push_slot (push_slot),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .head_slot (head_slot),
      .q_stat    (q_stat)
   );

   mbd_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head_cmd  (head_cmd),
      .head_slot (head_slot),
      .pop       (pop),
      .b_stat    (b_stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // no transfer into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full))
      else $error("push into full queue");

   // no pop from an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_stat.empty))
      else $error("pop from empty queue");

   // an averaged pixel always lands in the output register
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      b_stat.emit_fire |=> rsp_valid)
      else $error("emitted pixel not presented");

   // the back stage only emits while it holds a valid command
   a_fire_valid: assert property (@(posedge clock) disable iff (reset)
      b_stat.emit_fire |-> b_stat.stage_valid)
      else $error("emit without valid stage");

endmodule
